[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// c must hold in the same cycle as a
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// c must hold in the cycle after a
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

[rtl/core/rob_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the reorder buffer: field widths, result kinds,
// control state and the slot and cell-control structs. No dependencies.
package rob_pkg;

  localparam int SEQ_W = 16;
  localparam int TAG_W = 16;
  localparam int LEN_W = 11;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_FIN     = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

[rtl/core/rob_cell.sv]
`timescale 1ns / 1ps
// One window cell: holds the parked request at a fixed offset from the expected
// sequence number. Depends on rob_pkg.
module rob_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rob_pkg::cell_ctl_t       ctl,
  input  rob_pkg::slot_t           nbr_i,
  input  logic [rob_pkg::TAG_W-1:0] wr_tag,
  input  logic [rob_pkg::LEN_W-1:0] wr_len,
  output rob_pkg::slot_t           slot_o
);
  import rob_pkg::*;

  logic             valid_r, valid_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    if (ctl.shift) begin
      // advance: take the neighbor one offset further out
      valid_nxt = nbr_i.valid;
      tag_nxt   = nbr_i.tag;
      len_nxt   = nbr_i.len;
    end else if (ctl.load && !valid_r) begin
      // park; keep the first copy of a duplicate
      valid_nxt = 1'b1;
      tag_nxt   = wr_tag;
      len_nxt   = wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    len_r <= len_nxt;
  end

  assign slot_o = '{valid: valid_r, tag: tag_r, len: len_r};

endmodule

[rtl/core/reorder_buffer_cumulative_ack.sv]
`timescale 1ns / 1ps
// Reorder buffer with cumulative acknowledgement, built as a chain of WINDOW-1 cells.
// A dropped, parked or end request gives its single result, registered, and stays idle.
// An in-order request that releases k parked successors gives k+1 deliveries and
// an ack; the chain shifts one slot to the head per cycle, input stalled, output free.
// Synchronous active-low reset clears the expected number, all cell valid bits and
// the output valid; the block takes requests in the first cycle after reset.
module reorder_buffer_cumulative_ack #(
  parameter int WINDOW     = 32,
  parameter int SEQ_BITS   = 16,
  parameter int MAX_LENGTH = 1392
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rob_pkg::SEQ_W-1:0] in_seq_no,
  input  logic [rob_pkg::TAG_W-1:0] in_payload_tag,
  input  logic [rob_pkg::LEN_W-1:0] in_payload_length,
  input  logic                      in_is_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rob_pkg::kind_t            out_kind,
  output logic [rob_pkg::SEQ_W-1:0] out_out_seq,
  output logic [rob_pkg::TAG_W-1:0] out_out_tag,
  output logic [rob_pkg::LEN_W-1:0] out_out_length,
  output logic [rob_pkg::SEQ_W-1:0] out_ack_no,
  output logic                      out_last
);
  import rob_pkg::*;

  localparam int NCELL = WINDOW - 1;

  state_t              state_r, state_nxt;
  logic [SEQ_BITS-1:0] expected_r, expected_nxt;
  logic                out_valid_r, out_valid_nxt;
  kind_t               kind_r, kind_nxt;
  logic [SEQ_W-1:0]    seq_r, seq_nxt;
  logic [TAG_W-1:0]    tag_r, tag_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [SEQ_W-1:0]    ack_r, ack_nxt;
  logic                last_r, last_nxt;

  logic                out_free;
  logic                in_acc;
  logic                out_load;
  logic                shift_en;
  logic [SEQ_BITS-1:0] in_seq_w;
  logic [SEQ_BITS-1:0] off;
  logic [SEQ_W-1:0]    ack_cur;
  logic [SEQ_W-1:0]    exp_out;
  logic [LEN_W-1:0]    len_sat;

  slot_t     slots [NCELL];
  slot_t     nbr   [NCELL];
  cell_ctl_t ctl   [NCELL];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE && out_free);
  assign in_acc   = in_valid && !in_stall;

  assign in_seq_w = SEQ_BITS'(in_seq_no);
  assign off      = in_seq_w - expected_r;
  assign ack_cur  = SEQ_W'(expected_r - SEQ_BITS'(1));
  assign exp_out  = SEQ_W'(expected_r);
  assign len_sat  = (in_payload_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                              : in_payload_length;

  // cell j holds offset j+1 from the expected number
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    if (j == NCELL - 1) begin : g_tail
      assign nbr[j] = '0;
    end else begin : g_mid
      assign nbr[j] = slots[j+1];
    end
    assign ctl[j].shift = shift_en;
    assign ctl[j].load  = in_acc && !in_is_end && (off == SEQ_BITS'(j + 1));

    rob_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl[j]),
      .nbr_i  (nbr[j]),
      .wr_tag (in_payload_tag),
      .wr_len (len_sat),
      .slot_o (slots[j])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    expected_nxt = expected_r;
    shift_en     = 1'b0;
    out_load     = 1'b0;
    kind_nxt     = KIND_ACK;
    seq_nxt      = '0;
    tag_nxt      = '0;
    len_nxt      = '0;
    ack_nxt      = ack_cur;
    last_nxt     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          if (in_is_end) begin
            kind_nxt = KIND_FIN;
          end else if (off == '0) begin
            kind_nxt     = KIND_DELIVER;
            seq_nxt      = SEQ_W'(in_seq_w);
            tag_nxt      = in_payload_tag;
            len_nxt      = len_sat;
            ack_nxt      = SEQ_W'(in_seq_w);
            last_nxt     = 1'b0;
            expected_nxt = expected_r + SEQ_BITS'(1);
            state_nxt    = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (slots[0].valid) begin
            // release the parked head and advance the chain
            kind_nxt     = KIND_DELIVER;
            seq_nxt      = exp_out;
            tag_nxt      = slots[0].tag;
            len_nxt      = slots[0].len;
            ack_nxt      = exp_out;
            last_nxt     = 1'b0;
            shift_en     = 1'b1;
            expected_nxt = expected_r + SEQ_BITS'(1);
          end else begin
            // drop the empty head so cell 0 holds offset 1 again
            shift_en  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      expected_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      expected_r  <= expected_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_r <= kind_nxt;
      seq_r  <= seq_nxt;
      tag_r  <= tag_nxt;
      len_r  <= len_nxt;
      ack_r  <= ack_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_out_seq    = seq_r;
  assign out_out_tag    = tag_r;
  assign out_out_length = len_r;
  assign out_ack_no     = ack_r;
  assign out_last       = last_r;

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_drain_has_out, clk, rst_n, state_r == ST_DRAIN, out_valid_r, "drain without pending result")
  `ASSERT_NEXT(a_inorder_delivers, clk, rst_n, in_acc && !in_is_end && off == '0, state_r == ST_DRAIN && kind_r == KIND_DELIVER && !last_r, "in-order request not delivered")
  `ASSERT_NEXT(a_shift_advances, clk, rst_n, shift_en && slots[0].valid, expected_r == $past(expected_r) + SEQ_BITS'(1), "shift without advance")

endmodule

[dv/rob_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the reorder buffer: keeps its own receive window from accepted requests,
// predicts every delivery, acknowledgement and finish result and compares them in order.
// Depends on rob_pkg.
module rob_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [rob_pkg::SEQ_W-1:0] in_seq_no,
  input  logic [rob_pkg::TAG_W-1:0] in_payload_tag,
  input  logic [rob_pkg::LEN_W-1:0] in_payload_length,
  input  logic                      in_is_end,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  rob_pkg::kind_t            out_kind,
  input  logic [rob_pkg::SEQ_W-1:0] out_out_seq,
  input  logic [rob_pkg::TAG_W-1:0] out_out_tag,
  input  logic [rob_pkg::LEN_W-1:0] out_out_length,
  input  logic [rob_pkg::SEQ_W-1:0] out_ack_no,
  input  logic                      out_last,
  output int                        fail_count,
  output int                        outstanding
);
  import rob_pkg::*;

  localparam int WINDOW     = 32;
  localparam int MAX_LENGTH = 1392;

  typedef struct {
    kind_t            kind;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] ack;
    logic             last;
  } rob_result_t;

  rob_result_t      due_results [$];
  logic [SEQ_W-1:0] next_seq;
  logic [4:0]       head;
  logic             park_vld [WINDOW];
  logic [TAG_W-1:0] park_tag [WINDOW];
  logic [LEN_W-1:0] park_len [WINDOW];
  int               fails = 0;

  function automatic rob_result_t make_result(kind_t k, logic [SEQ_W-1:0] s,
                                              logic [TAG_W-1:0] t, logic [LEN_W-1:0] l,
                                              logic [SEQ_W-1:0] a, logic lst);
    rob_result_t r;
    r.kind = k;
    r.seq  = s;
    r.tag  = t;
    r.len  = l;
    r.ack  = a;
    r.last = lst;
    return r;
  endfunction

  task automatic compute_releases(input logic [SEQ_W-1:0] seq, input logic [TAG_W-1:0] tag,
                                  input logic [LEN_W-1:0] len_in, input logic is_end);
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] off;
    logic [4:0]       slot;
    int               n;
    len = (len_in > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : len_in;
    if (is_end) begin
      due_results.push_back(make_result(KIND_FIN, '0, '0, '0, next_seq - 1'b1, 1'b1));
      return;
    end
    off = seq - next_seq;
    if (off == 0) begin
      due_results.push_back(make_result(KIND_DELIVER, seq, tag, len, seq, 1'b0));
      n = 1;
      next_seq++;
      head++;
      // release parked successors in sequence order
      while (n < WINDOW && park_vld[head]) begin
        due_results.push_back(make_result(KIND_DELIVER, next_seq, park_tag[head],
                                          park_len[head], next_seq, 1'b0));
        park_vld[head] = 1'b0;
        next_seq++;
        head++;
        n++;
      end
    end else if (off < WINDOW) begin
      slot = head + off[4:0];
      // keep the first copy of a parked request
      if (!park_vld[slot]) begin
        park_vld[slot] = 1'b1;
        park_tag[slot] = tag;
        park_len[slot] = len;
      end
    end
    due_results.push_back(make_result(KIND_ACK, '0, '0, '0, next_seq - 1'b1, 1'b1));
  endtask

  task automatic compare_field(input string name, input logic [SEQ_W-1:0] want,
                               input logic [SEQ_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic check_result();
    rob_result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: kind %0d seq %0d ack %0d", out_kind, out_out_seq, out_ack_no);
      fails++;
      return;
    end
    want = due_results.pop_front();
    compare_field("out_kind", SEQ_W'(want.kind), SEQ_W'(out_kind));
    compare_field("out_out_seq", want.seq, out_out_seq);
    compare_field("out_out_tag", want.tag, out_out_tag);
    compare_field("out_out_length", SEQ_W'(want.len), SEQ_W'(out_out_length));
    compare_field("out_ack_no", want.ack, out_ack_no);
    compare_field("out_last", SEQ_W'(want.last), SEQ_W'(out_last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      next_seq = '0;
      head     = '0;
      foreach (park_vld[i]) park_vld[i] = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall)
        compute_releases(in_seq_no, in_payload_tag, in_payload_length, in_is_end);
    end
    fail_count  <= fails;
    outstanding <= due_results.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the reorder buffer testbench: clock, reset, request stimulus and receiver stalls.
// Depends on rob_pkg, the reorder_buffer_cumulative_ack RTL and rob_checker.
module tb_top;
  import rob_pkg::*;

  localparam int WINDOW          = 32;
  localparam int MAX_LENGTH      = 1392;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int CYCLE_LIMIT     = 400000;

  logic             clk;
  logic             rst_n             = 1'b0;
  logic             in_valid          = 1'b0;
  logic             in_stall;
  logic [SEQ_W-1:0] in_seq_no         = '0;
  logic [TAG_W-1:0] in_payload_tag    = '0;
  logic [LEN_W-1:0] in_payload_length = '0;
  logic             in_is_end         = 1'b0;
  logic             out_valid;
  logic             out_stall         = 1'b0;
  kind_t            out_kind;
  logic [SEQ_W-1:0] out_out_seq;
  logic [TAG_W-1:0] out_out_tag;
  logic [LEN_W-1:0] out_out_length;
  logic [SEQ_W-1:0] out_ack_no;
  logic             out_last;

  int               fail_count;
  int               outstanding;
  int               idle_pct  = 0;
  int               stall_pct = 0;
  int               cycles    = 0;
  int               sent      = 0;
  logic [SEQ_W-1:0] win_base;

  reorder_buffer_cumulative_ack u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_seq_no        (in_seq_no),
    .in_payload_tag   (in_payload_tag),
    .in_payload_length(in_payload_length),
    .in_is_end        (in_is_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_out_seq      (out_out_seq),
    .out_out_tag      (out_out_tag),
    .out_out_length   (out_out_length),
    .out_ack_no       (out_ack_no),
    .out_last         (out_last)
  );

  rob_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_seq_no        (in_seq_no),
    .in_payload_tag   (in_payload_tag),
    .in_payload_length(in_payload_length),
    .in_is_end        (in_is_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_out_seq      (out_out_seq),
    .out_out_tag      (out_out_tag),
    .out_out_length   (out_out_length),
    .out_ack_no       (out_ack_no),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [LEN_W-1:0] pick_length();
    if ($urandom_range(0, 9) == 0) return LEN_W'($urandom_range(MAX_LENGTH + 1, 2047));
    return LEN_W'($urandom_range(0, MAX_LENGTH));
  endfunction

  task automatic send_request(input logic [SEQ_W-1:0] seq, input logic [TAG_W-1:0] tag,
                              input logic [LEN_W-1:0] len, input logic is_end);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_seq_no         <= seq;
    in_payload_tag    <= tag;
    in_payload_length <= len;
    in_is_end         <= is_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_data(input logic [SEQ_W-1:0] seq);
    send_request(seq, TAG_W'($urandom), pick_length(), 1'b0);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_data(win_base - 1'b1 - SEQ_W'($urandom_range(0, 2000)));
      1: send_data(win_base + SEQ_W'(WINDOW) + SEQ_W'($urandom_range(0, 2000)));
      2: send_data(SEQ_W'($urandom));
      default: send_request(SEQ_W'($urandom), TAG_W'($urandom), LEN_W'($urandom), 1'b1);
    endcase
  endtask

  // up to WINDOW requests, maybe reordered, with duplicates and stray traffic mixed in
  task automatic send_burst(input int count);
    logic [SEQ_W-1:0] order [$];
    logic [SEQ_W-1:0] tmp;
    int               mode;
    int               i;
    int               j;
    mode = $urandom_range(0, 3);
    for (i = 0; i < count; i++) begin
      if (mode == 1) order.push_front(win_base + SEQ_W'(i));
      else order.push_back(win_base + SEQ_W'(i));
    end
    if (mode == 2) begin
      for (i = count - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end else if (mode == 3) begin
      // lose the head request and retransmit it last
      tmp = order.pop_front();
      order.push_back(tmp);
    end
    for (i = 0; i < count; i++) begin
      send_data(order[i]);
      if ($urandom_range(0, 7) == 0) send_data(order[$urandom_range(0, i)]);
      if ($urandom_range(0, 11) == 0) send_noise();
    end
    win_base += SEQ_W'(count);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  int idle_sched  [4] = '{0, 67, 0, 24};
  int stall_sched [4] = '{0, 0, 67, 24};

  initial begin
    int target;
    int r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_request(16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1);
    send_request(16'd0, 16'h0000, 11'd0, 1'b0);
    send_request(16'd1, 16'hFFFF, 11'h7FF, 1'b0);
    send_request(16'd3, 16'h5A5A, LEN_W'(MAX_LENGTH), 1'b0);
    send_request(16'd3, 16'hA5A5, 11'd17, 1'b0);
    send_request(16'd2, 16'h1234, 11'd64, 1'b0);
    send_request(16'd0, 16'h4321, 11'd5, 1'b0);
    send_request(16'd4 + SEQ_W'(WINDOW) - 1'b1, 16'hBEEF, LEN_W'(MAX_LENGTH + 1), 1'b0);
    send_request(16'd4 + SEQ_W'(WINDOW), 16'hDEAD, 11'd100, 1'b0);
    send_request(16'd0, 16'h0000, 11'd0, 1'b1);
    send_request(16'hFFFF, 16'h8001, 11'd1024, 1'b0);
    send_request(16'd4, 16'h00FF, 11'd2, 1'b0);
    win_base = 16'd5;
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_sched[p];
      stall_pct = stall_sched[p];
      target    = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        r = $urandom_range(0, 9);
        if (r == 0) send_noise();
        else if (r == 1) send_burst(WINDOW);
        else if (r == 2) send_burst($urandom_range(9, WINDOW - 1));
        else send_burst($urandom_range(1, 8));
        // hold off now and then until every result is back
        if ($urandom_range(0, 15) == 0) drain_results();
      end
      drain_results();
    end

    stall_pct = 0;
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
